/* sv/wsd_pkg.sv */
// Shared types and constants of the WebSocket frame deframer.
// Used by wsd_parse, wsd_outbuf and websocket_frame_deframer; no dependencies.
package wsd_pkg;

	localparam int LEN_W = 17;
	localparam int CODE_W = 10;

	localparam logic [LEN_W-1:0] MAX_MESSAGE_RST = 17'h10000;
	localparam logic [6:0] LEN7_MAX_SHORT = 7'd125;
	localparam logic [6:0] LEN7_EXT16 = 7'd126;
	localparam logic [6:0] LEN7_EXT64 = 7'd127;

	localparam logic [3:0] OP_TEXT = 4'h1;
	localparam logic [3:0] OP_BINARY = 4'h2;
	localparam logic [3:0] OP_CLOSE = 4'h8;
	localparam logic [3:0] OP_PING = 4'h9;
	localparam logic [3:0] OP_PONG = 4'hA;

	localparam logic [CODE_W-1:0] CODE_NONE = 10'd0;
	localparam logic [CODE_W-1:0] CODE_PROTOCOL = 10'd1002;
	localparam logic [CODE_W-1:0] CODE_UNSUPPORTED = 10'd1003;
	localparam logic [CODE_W-1:0] CODE_TOO_BIG = 10'd1009;

	localparam logic [2:0] REG_MAX_MESSAGE = 3'd0;

	typedef enum logic [3:0] {
		ACT_NONE = 4'd0,
		ACT_TEXT = 4'd1,
		ACT_PONG = 4'd2,
		ACT_ECHO_CLOSE = 4'd3,
		ACT_IGNORE = 4'd4,
		ACT_PROTOCOL = 4'd5,
		ACT_TOO_LARGE = 4'd6,
		ACT_BINARY = 4'd7,
		ACT_FRAGMENTED = 4'd8,
		ACT_BAD_OPCODE = 4'd9
	} action_t;

	typedef struct packed {
		logic has_data;
		logic [7:0] data;
		logic frame_end;
		action_t action;
		logic [CODE_W-1:0] close_code;
		logic [3:0] frame_opcode;
	} result_t;

endpackage

/* sv/wsd_parse.sv */
// Per-byte frame parser: header, extended length, mask key and payload unmasking.
// Depends on wsd_pkg; result is combinational and registered in wsd_outbuf.
module wsd_parse (
	input logic clk,
	input logic arst_n,
	input logic in_accept,
	input logic [7:0] byte_in,
	input logic [wsd_pkg::LEN_W-1:0] max_message,
	output logic res_valid,
	output wsd_pkg::result_t res
);

	typedef enum logic [2:0] {
		PH_HEAD1 = 3'd0,
		PH_HEAD2 = 3'd1,
		PH_EXT = 3'd2,
		PH_MASK = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_CLOSED = 3'd5
	} phase_t;

	phase_t phase_q, phase_d;
	logic fin_q, fin_d;
	logic [3:0] opcode_q, opcode_d;
	logic [wsd_pkg::LEN_W-1:0] length_q, length_d;
	logic over_q, over_d;
	logic [2:0] ext_left_q, ext_left_d;
	logic [31:0] key_q, key_d;
	logic [1:0] idx_q, idx_d;
	logic [wsd_pkg::LEN_W-1:0] left_q, left_d;

	wsd_pkg::action_t fin_act;
	logic [wsd_pkg::CODE_W-1:0] fin_code;
	phase_t fin_phase;
	logic [wsd_pkg::LEN_W+7:0] ext_val;
	logic [wsd_pkg::LEN_W-1:0] len_short;
	logic [7:0] key_byte;
	logic [7:0] plain;

	always_comb begin
		fin_code = wsd_pkg::CODE_NONE;
		if (opcode_q[3] && (!fin_q || length_q > wsd_pkg::LEN_W'(wsd_pkg::LEN7_MAX_SHORT))) begin
			fin_act = wsd_pkg::ACT_PROTOCOL;
			fin_code = wsd_pkg::CODE_PROTOCOL;
		end else if (!fin_q) begin
			fin_act = wsd_pkg::ACT_FRAGMENTED;
			fin_code = wsd_pkg::CODE_PROTOCOL;
		end else if (opcode_q == wsd_pkg::OP_TEXT) begin
			fin_act = wsd_pkg::ACT_TEXT;
		end else if (opcode_q == wsd_pkg::OP_BINARY) begin
			fin_act = wsd_pkg::ACT_BINARY;
			fin_code = wsd_pkg::CODE_UNSUPPORTED;
		end else if (opcode_q == wsd_pkg::OP_CLOSE) begin
			fin_act = wsd_pkg::ACT_ECHO_CLOSE;
		end else if (opcode_q == wsd_pkg::OP_PING) begin
			fin_act = wsd_pkg::ACT_PONG;
		end else if (opcode_q == wsd_pkg::OP_PONG) begin
			fin_act = wsd_pkg::ACT_IGNORE;
		end else begin
			fin_act = wsd_pkg::ACT_BAD_OPCODE;
			fin_code = wsd_pkg::CODE_PROTOCOL;
		end
		if (fin_act == wsd_pkg::ACT_TEXT || fin_act == wsd_pkg::ACT_PONG ||
				fin_act == wsd_pkg::ACT_IGNORE) begin
			fin_phase = PH_HEAD1;
		end else begin
			fin_phase = PH_CLOSED;
		end
	end

	assign ext_val = {length_q, byte_in};
	assign len_short = wsd_pkg::LEN_W'(byte_in[6:0]);

	always_comb begin
		case (idx_q)
			2'd0: key_byte = key_q[31:24];
			2'd1: key_byte = key_q[23:16];
			2'd2: key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end
	assign plain = byte_in ^ key_byte;

	always_comb begin
		phase_d = phase_q;
		fin_d = fin_q;
		opcode_d = opcode_q;
		length_d = length_q;
		over_d = over_q;
		ext_left_d = ext_left_q;
		key_d = key_q;
		idx_d = idx_q;
		left_d = left_q;
		res_valid = 1'b0;
		res.has_data = 1'b0;
		res.data = 8'h00;
		res.frame_end = 1'b0;
		res.action = wsd_pkg::ACT_NONE;
		res.close_code = wsd_pkg::CODE_NONE;
		case (phase_q)
			PH_HEAD1: begin
				fin_d = byte_in[7];
				opcode_d = byte_in[3:0];
				if (byte_in[6:4] != 3'b000) begin
					phase_d = PH_CLOSED;
					res_valid = 1'b1;
					res.frame_end = 1'b1;
					res.action = wsd_pkg::ACT_PROTOCOL;
					res.close_code = wsd_pkg::CODE_PROTOCOL;
				end else begin
					phase_d = PH_HEAD2;
				end
			end
			PH_HEAD2: begin
				length_d = '0;
				over_d = 1'b0;
				if (!byte_in[7]) begin
					phase_d = PH_CLOSED;
					res_valid = 1'b1;
					res.frame_end = 1'b1;
					res.action = wsd_pkg::ACT_PROTOCOL;
					res.close_code = wsd_pkg::CODE_PROTOCOL;
				end else if (byte_in[6:0] == wsd_pkg::LEN7_EXT16) begin
					ext_left_d = 3'd1;
					phase_d = PH_EXT;
				end else if (byte_in[6:0] == wsd_pkg::LEN7_EXT64) begin
					ext_left_d = 3'd7;
					phase_d = PH_EXT;
				end else begin
					length_d = len_short;
					if (len_short > max_message) begin
						phase_d = PH_CLOSED;
						res_valid = 1'b1;
						res.frame_end = 1'b1;
						res.action = wsd_pkg::ACT_TOO_LARGE;
						res.close_code = wsd_pkg::CODE_TOO_BIG;
					end else begin
						phase_d = PH_MASK;
						idx_d = 2'd0;
					end
				end
			end
			PH_EXT: begin
				over_d = over_q | (ext_val[wsd_pkg::LEN_W+7:wsd_pkg::LEN_W] != 8'h00);
				length_d = ext_val[wsd_pkg::LEN_W-1:0];
				if (ext_left_q == 3'd0) begin
					if (over_d || length_d > max_message) begin
						phase_d = PH_CLOSED;
						res_valid = 1'b1;
						res.frame_end = 1'b1;
						res.action = wsd_pkg::ACT_TOO_LARGE;
						res.close_code = wsd_pkg::CODE_TOO_BIG;
					end else begin
						phase_d = PH_MASK;
						idx_d = 2'd0;
					end
				end else begin
					ext_left_d = ext_left_q - 3'd1;
				end
			end
			PH_MASK: begin
				key_d = {key_q[23:0], byte_in};
				if (idx_q == 2'd3) begin
					idx_d = 2'd0;
					left_d = length_q;
					if (length_q == '0) begin
						phase_d = fin_phase;
						res_valid = 1'b1;
						res.frame_end = 1'b1;
						res.action = fin_act;
						res.close_code = fin_code;
					end else begin
						phase_d = PH_PAYLOAD;
					end
				end else begin
					idx_d = idx_q + 2'd1;
				end
			end
			PH_PAYLOAD: begin
				idx_d = idx_q + 2'd1;
				left_d = (left_q != '0) ? left_q - wsd_pkg::LEN_W'(1) : left_q;
				res_valid = 1'b1;
				res.has_data = 1'b1;
				res.data = plain;
				if (left_d == '0) begin
					phase_d = fin_phase;
					res.frame_end = 1'b1;
					res.action = fin_act;
					res.close_code = fin_code;
				end
			end
			default: begin
				phase_d = PH_CLOSED;
			end
		endcase
		res.frame_opcode = opcode_d;
		res_valid = res_valid & in_accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEAD1;
			fin_q <= 1'b0;
			opcode_q <= 4'h0;
			length_q <= '0;
			over_q <= 1'b0;
			ext_left_q <= 3'd0;
			key_q <= 32'h0;
			idx_q <= 2'd0;
			left_q <= '0;
		end else if (in_accept) begin
			phase_q <= phase_d;
			fin_q <= fin_d;
			opcode_q <= opcode_d;
			length_q <= length_d;
			over_q <= over_d;
			ext_left_q <= ext_left_d;
			key_q <= key_d;
			idx_q <= idx_d;
			left_q <= left_d;
		end
	end

`ifndef SYNTHESIS
	a_no_result_closed: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_CLOSED |-> !res_valid)
		else $error("result produced while closed");
	a_mid_frame_no_action: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.frame_end |-> res.has_data && res.action == wsd_pkg::ACT_NONE)
		else $error("action outside frame end");
	a_payload_left_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> left_q != '0)
		else $error("payload phase with nothing left");
`endif

endmodule

/* sv/wsd_outbuf.sv */
// Result register with skid stage between the parser and the master stream.
// Depends on wsd_pkg for the result type.
module wsd_outbuf (
	input logic clk,
	input logic arst_n,
	input logic push,
	input wsd_pkg::result_t push_res,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	output wsd_pkg::result_t out_res
);

	logic main_v_q;
	logic skid_v_q;
	wsd_pkg::result_t main_q;
	wsd_pkg::result_t skid_q;
	logic pop;

	assign pop = main_v_q & out_ready;
	assign in_ready = ~skid_v_q;
	assign out_valid = main_v_q;
	assign out_res = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (push) begin
			if (!main_v_q || pop) begin
				main_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (pop) begin
			main_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				main_q <= skid_q;
			end
		end else if (push) begin
			if (!main_v_q || pop) begin
				main_q <= push_res;
			end else begin
				skid_q <= push_res;
			end
		end
	end

`ifndef SYNTHESIS
	a_skid_needs_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> main_v_q)
		else $error("skid holds a transfer while output is empty");
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !skid_v_q)
		else $error("result pushed into full buffer");
	a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(main_v_q && !out_ready))
		else $error("skid filled without stall");
`endif

endmodule

/* sv/websocket_frame_deframer.sv */
// WebSocket client-to-server frame deframer, top level with APB register.
// Depends on wsd_pkg, wsd_parse and wsd_outbuf.
//
// Usage: stream bytes on the slave channel (s_tdata = byte_in), one per
// transfer. Header, extended-length and mask bytes give no data byte; each
// payload byte comes out unmasked on the master channel. m_tlast marks frame
// end or a rejection, and then the action and close code are valid.
// Register max_message (byte address 0, reset 65536) limits payload length;
// write it only while the block is idle.
// Results are registered in the output buffer ahead of m_tvalid.
// Throughput: one byte per cycle while s_tready is high.
// Reset: parser returns to the first header byte, output buffer empties.
// Stall: a two-entry output buffer absorbs one result while m_tready is low;
// s_tready drops only when both entries are full. After a closing action
// all further bytes are taken and dropped until reset.
module websocket_frame_deframer (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input logic s_tvalid,
	output logic s_tready,
	input logic [7:0] s_tdata,        // [7:0] byte_in
	output logic m_tvalid,
	input logic m_tready,
	output logic [31:0] m_tdata,      // [7:0] data, [11:8] action, [21:12] close_code,
	                                  // [25:22] frame_opcode, [31:26] zero
	output logic m_tlast,
	output logic m_tuser              // [0] has_data
);

	logic [wsd_pkg::LEN_W-1:0] max_message_q;
	logic in_accept;
	logic res_valid;
	wsd_pkg::result_t res;
	wsd_pkg::result_t out_res;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_message_q <= wsd_pkg::MAX_MESSAGE_RST;
		end else if (psel && penable && pwrite && pready &&
				paddr[2] == wsd_pkg::REG_MAX_MESSAGE[0]) begin
			max_message_q <= pwdata[wsd_pkg::LEN_W-1:0];
		end
	end

	assign prdata = (paddr[2] == wsd_pkg::REG_MAX_MESSAGE[0]) ?
		{{(32-wsd_pkg::LEN_W){1'b0}}, max_message_q} : 32'h0;

	assign in_accept = s_tvalid & s_tready;

	wsd_parse u_parse (
		.clk(clk),
		.arst_n(arst_n),
		.in_accept(in_accept),
		.byte_in(s_tdata),
		.max_message(max_message_q),
		.res_valid(res_valid),
		.res(res)
	);

	wsd_outbuf u_outbuf (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_valid),
		.push_res(res),
		.in_ready(s_tready),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res(out_res)
	);

	assign m_tdata = {6'b000000, out_res.frame_opcode, out_res.close_code,
		out_res.action, out_res.data};
	assign m_tlast = out_res.frame_end;
	assign m_tuser = out_res.has_data;

endmodule
